### hdl/input_combo_remapper_core_assert.svh
// assertion macros for the combo remapper
`ifndef INPUT_COMBO_REMAPPER_CORE_ASSERT_SVH
`define INPUT_COMBO_REMAPPER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define ICR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication outside reset
`define ICR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/icr_pkg.sv
// ----------------------------------------------------------------------------
// icr_pkg
// types and constants shared by the combo remapper files
// ----------------------------------------------------------------------------
package icr_pkg;

   localparam int RulesDefault       = 8;
   localparam int KeysPerRuleDefault = 4;
   localparam int HeadWidth          = 49;
   localparam int WordWidth          = 64;

   localparam logic [2:0] ActKey     = 3'd0;
   localparam logic [2:0] ActApply   = 3'd1;
   localparam logic [2:0] ActHead    = 3'd2;
   localparam logic [2:0] ActKeys    = 3'd3;
   localparam logic [2:0] ActDisable = 3'd4;

   localparam logic KindAck   = 1'b0;
   localparam logic KindFrame = 1'b1;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  key_usage;
      logic        key_down;
      logic [7:0]  modifiers;
      logic [15:0] mouse_buttons;
      logic [3:0]  slot;
      logic [63:0] rule_word;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [1:0]  word_index;
      logic [63:0] key_bits;
      logic [7:0]  out_modifiers;
      logic [15:0] out_mouse_buttons;
      logic        last;
   } rsp_type;

endpackage

### hdl/icr_ram.sv
// ----------------------------------------------------------------------------
// icr_ram
// generic single-port-write ram with one registered read port
// ----------------------------------------------------------------------------
module icr_ram #(
   parameter int Width = 64,
   parameter int Depth = 8
) (
   input  logic                                             clock,
   input  logic                                             wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]     wr_addr,
   input  logic [Width-1:0]                                 wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]     rd_addr,
   output logic [Width-1:0]                                 rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hdl/input_combo_remapper_core.sv
// ----------------------------------------------------------------------------
// input_combo_remapper_core
// key bitmap and combo rule table; apply walks the rules and emits four words
// ----------------------------------------------------------------------------
// channel | ports             | handshake
// req     | req_payload       | start & !busy
// rsp     | rsp_payload       | rsp_valid, one cycle, no stall
// sequencing: the ack of a rule write/disable comes in the next cycle; apply
//   does one rule read and one evaluate step per rule from the rule memories,
//   then four frame words on consecutive cycles.
// reset: rule enable bits, key valid bits, bitmap and control cleared at once;
//   a disabled rule is never matched and an unwritten key entry reads as zero.
// stalls: busy holds new transactions off while an apply or an ack runs.
module input_combo_remapper_core #(
   parameter int Rules       = icr_pkg::RulesDefault,
   parameter int KeysPerRule = icr_pkg::KeysPerRuleDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  icr_pkg::req_type req_payload,
   output logic             busy,
   output logic             rsp_valid,
   output icr_pkg::rsp_type rsp_payload
);
   localparam int AW = (Rules > 1) ? $clog2(Rules) : 1;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_EMIT} state_type;

   state_type   state_ff;
   logic [AW:0] cursor_ff;
   logic [1:0]  word_ff;
   logic [Rules-1:0] enabled_ff;
   logic [Rules-1:0] kvalid_ff;
   logic [63:0] pressed_ff [4];
   logic [63:0] frame_ff [4];
   logic [7:0]  fmods_ff, amods_ff;
   logic [15:0] fbtns_ff, abtns_ff;
   logic        rsp_valid_ff;
   icr_pkg::rsp_type rsp_ff;

   logic        accept;
   logic        slot_ok;
   logic [AW-1:0] waddr;
   logic        head_we, keys_we;
   logic [icr_pkg::HeadWidth-1:0] head_wd, head_rd;
   logic [63:0] keys_wd, keys_rd, keys_use;
   logic [AW-1:0] raddr;

   assign accept  = start && !busy;
   assign slot_ok = {1'b0, req_payload.slot} < 5'(Rules);
   assign waddr   = AW'(req_payload.slot);
   assign head_we = accept && slot_ok &&
                    (req_payload.action == icr_pkg::ActHead ||
                     req_payload.action == icr_pkg::ActDisable);
   assign keys_we = accept && slot_ok &&
                    (req_payload.action == icr_pkg::ActKeys ||
                     req_payload.action == icr_pkg::ActDisable);
   assign head_wd = (req_payload.action == icr_pkg::ActHead) ?
                    req_payload.rule_word[icr_pkg::HeadWidth-1:0] : '0;
   assign keys_wd = (req_payload.action == icr_pkg::ActKeys) ?
                    req_payload.rule_word : '0;
   assign raddr   = cursor_ff[AW-1:0];
   // key entries never written since reset count as all zero
   assign keys_use = kvalid_ff[raddr] ? keys_rd : '0;

   icr_ram #(.Width(icr_pkg::HeadWidth), .Depth(Rules)) u_heads (
      .clock, .wr_en(head_we), .wr_addr(waddr), .wr_data(head_wd),
      .rd_addr(raddr), .rd_data(head_rd));
   icr_ram #(.Width(64), .Depth(Rules)) u_keys (
      .clock, .wr_en(keys_we), .wr_addr(waddr), .wr_data(keys_wd),
      .rd_addr(raddr), .rd_data(keys_rd));

   // match test and frame update for the rule just read
   logic        hit;
   logic [63:0] frame_in [4];
   logic [7:0]  fmods_in;
   logic [15:0] fbtns_in;
   always_comb begin
      logic [7:0] u;
      hit = enabled_ff[raddr] &&
            ((amods_ff & head_rd[7:0]) == head_rd[7:0]) &&
            ((abtns_ff & head_rd[23:8]) == head_rd[23:8]);
      for (int i = 0; i < KeysPerRule; i++) begin
         u = keys_use[8*i +: 8];
         if (u != 8'd0 && !pressed_ff[u[7:6]][u[5:0]]) hit = 1'b0;
      end
      frame_in = frame_ff;
      fmods_in = fmods_ff;
      fbtns_in = fbtns_ff;
      if (hit) begin
         if (head_rd[48]) begin
            fmods_in = fmods_in & ~head_rd[7:0];
            fbtns_in = fbtns_in & ~head_rd[23:8];
            for (int i = 0; i < KeysPerRule; i++) begin
               u = keys_use[8*i +: 8];
               if (u != 8'd0) frame_in[u[7:6]][u[5:0]] = 1'b0;
            end
         end
         fmods_in = fmods_in | head_rd[31:24];
         fbtns_in = fbtns_in | head_rd[47:32];
         for (int i = 0; i < KeysPerRule; i++) begin
            u = keys_use[32 + 8*i +: 8];
            if (u != 8'd0) frame_in[u[7:6]][u[5:0]] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         word_ff      <= '0;
         enabled_ff   <= '0;
         kvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         fmods_ff     <= '0;
         fbtns_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            pressed_ff[i] <= '0;
            frame_ff[i]   <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_payload.action)
                     icr_pkg::ActKey: begin
                        pressed_ff[req_payload.key_usage[7:6]]
                                  [req_payload.key_usage[5:0]] <= req_payload.key_down;
                     end
                     icr_pkg::ActApply: begin
                        frame_ff  <= pressed_ff;
                        fmods_ff  <= req_payload.modifiers;
                        fbtns_ff  <= req_payload.mouse_buttons;
                        amods_ff  <= req_payload.modifiers;
                        abtns_ff  <= req_payload.mouse_buttons;
                        cursor_ff <= '0;
                        state_ff  <= S_READ;
                     end
                     icr_pkg::ActHead, icr_pkg::ActKeys, icr_pkg::ActDisable: begin
                        if (slot_ok) begin
                           if (req_payload.action == icr_pkg::ActHead)
                              enabled_ff[waddr] <= 1'b1;
                           else if (req_payload.action == icr_pkg::ActDisable)
                              enabled_ff[waddr] <= 1'b0;
                           if (req_payload.action != icr_pkg::ActHead)
                              kvalid_ff[waddr] <= 1'b1;
                        end
                        rsp_valid_ff             <= 1'b1;
                        rsp_ff.kind              <= icr_pkg::KindAck;
                        rsp_ff.status            <= !slot_ok;
                        rsp_ff.word_index        <= '0;
                        rsp_ff.key_bits          <= '0;
                        rsp_ff.out_modifiers     <= '0;
                        rsp_ff.out_mouse_buttons <= '0;
                        rsp_ff.last              <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: begin
               frame_ff <= frame_in;
               fmods_ff <= fmods_in;
               fbtns_ff <= fbtns_in;
               if (cursor_ff == (AW+1)'(Rules - 1)) begin
                  cursor_ff <= '0;
                  word_ff   <= '0;
                  state_ff  <= S_EMIT;
               end else begin
                  cursor_ff <= cursor_ff + 1'b1;
                  state_ff  <= S_READ;
               end
            end
            S_EMIT: begin
               rsp_valid_ff             <= 1'b1;
               rsp_ff.kind              <= icr_pkg::KindFrame;
               rsp_ff.status            <= 1'b0;
               rsp_ff.word_index        <= word_ff;
               rsp_ff.key_bits          <= frame_ff[word_ff];
               rsp_ff.out_modifiers     <= fmods_ff;
               rsp_ff.out_mouse_buttons <= fbtns_ff;
               rsp_ff.last              <= (word_ff == 2'd3);
               word_ff                  <= word_ff + 2'd1;
               if (word_ff == 2'd3) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`include "input_combo_remapper_core_assert.svh"
   `ICR_ASSERT_IMP(a_last_frame, clock, reset,
      rsp_valid && rsp_payload.kind == icr_pkg::KindFrame,
      rsp_payload.last == (rsp_payload.word_index == 2'd3))
   `ICR_ASSERT_NEXT(a_ack_follows, clock, reset,
      accept && (req_payload.action == icr_pkg::ActHead ||
                 req_payload.action == icr_pkg::ActKeys ||
                 req_payload.action == icr_pkg::ActDisable),
      rsp_valid && rsp_payload.kind == icr_pkg::KindAck)
   `ICR_ASSERT_IMP(a_busy_when_valid, clock, reset, rsp_valid, busy)
endmodule
